[rtl/core/aces_tm_pkg.sv]
// Shared constants, widths and coefficient tables for the ACES fitted tonemapper.
// No dependencies; used by every module under rtl/core.
`default_nettype none
package aces_tm_pkg;

    localparam int N_CH      = 3;
    localparam int PIX_W     = 24;   // Q8.16 input channel
    localparam int EXP_W     = 24;   // Q8.16 exposure multiplier
    localparam int OUT_W     = 16;   // Q0.16 output channel
    localparam int PEXP_W    = PIX_W + EXP_W;
    localparam int X_W       = 32;   // Q16.16 exposed color
    localparam int COEF_W    = 16;   // Q0.16 input matrix entry
    localparam int MPROD_W   = X_W + COEF_W;
    localparam int V_W       = 31;   // Q15.16, saturated
    localparam int F_W       = 17;   // Q1.16 fit result
    localparam int OCOEF_W   = 18;   // signed Q1.16 output matrix entry
    localparam int OPROD_W   = F_W + 1 + OCOEF_W;
    localparam int OSUM_W    = OPROD_W + 2;
    localparam int NUM_W     = 63;
    localparam int DIVD_W    = 47;

    // Pipeline depth per section
    localparam int FRONT_STAGES = 3;
    localparam int FIT_STAGES   = 4;
    localparam int DIV_STAGES   = F_W;
    localparam int LANE_STAGES  = FIT_STAGES + DIV_STAGES;
    localparam int MERGE_STAGES = 2;
    localparam int PIPE_STAGES  = FRONT_STAGES + LANE_STAGES + MERGE_STAGES;

    localparam logic [EXP_W-1:0] EXPOSURE_RESET = 24'd65536;
    localparam logic [V_W-1:0]   V_SAT          = 31'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_MAX        = 16'hFFFF;

    // Rational fit constants, Q0.32
    localparam logic [26:0] FIT_A = 27'd105564283;
    localparam logic [18:0] FIT_B = 19'd388853;
    localparam logic [31:0] FIT_C = 32'd4225083883;
    localparam logic [30:0] FIT_D = 31'd1859510386;
    localparam logic [29:0] FIT_E = 30'd1022550109;

    // [input channel][output channel]
    localparam logic [COEF_W-1:0] IN_MAT [N_CH][N_CH] = '{
        '{16'd39137, 16'd4981,  16'd1861},
        '{16'd23238, 16'd59529, 16'd8771},
        '{16'd3161,  16'd1026,  16'd54904}
    };

    localparam logic signed [OCOEF_W-1:0] OUT_MAT [N_CH][N_CH] = '{
        '{ 18'sd105169, -18'sd6690,  -18'sd214},
        '{-18'sd34805,   18'sd72622, -18'sd4768},
        '{-18'sd4828,   -18'sd396,    18'sd70518}
    };

endpackage
`default_nettype wire

[rtl/core/aces_tm_div.sv]
// Pipelined restoring divider, one quotient bit per stage (17-bit quotient).
// Depends on aces_tm_pkg.
`default_nettype none
module aces_tm_div (
    input  wire logic                                   aclk,
    input  wire logic [aces_tm_pkg::DIV_STAGES-1:0]     en,
    input  wire logic [aces_tm_pkg::NUM_W-1:0]          dividend,
    input  wire logic [aces_tm_pkg::DIVD_W-1:0]         divisor,
    output logic      [aces_tm_pkg::F_W-1:0]            quotient
);
    localparam int NS = aces_tm_pkg::DIV_STAGES;
    localparam int NW = aces_tm_pkg::NUM_W;
    localparam int DW = aces_tm_pkg::DIVD_W;
    localparam int QW = aces_tm_pkg::F_W;

    logic [NW-1:0] rem_reg [NS];
    logic [DW-1:0] d_reg   [NS];
    logic [QW-1:0] q_reg   [NS];

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            logic [NW-1:0] rem_in;
            logic [DW-1:0] d_in;
            logic [QW-1:0] q_in;
            logic [NW-1:0] sub;
            logic [NW-1:0] rem_next;
            logic [QW-1:0] q_next;

            if (k == 0) begin : g_first
                assign rem_in = dividend;
                assign d_in   = divisor;
                assign q_in   = '0;
            end else begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign d_in   = d_reg[k-1];
                assign q_in   = q_reg[k-1];
            end

            // trial subtract of the divisor aligned to quotient bit NS-1-k
            assign sub = NW'(d_in) << (NS - 1 - k);

            always_comb begin
                rem_next = rem_in;
                q_next   = q_in;
                if (rem_in >= sub) begin
                    rem_next                 = rem_in - sub;
                    q_next[NS - 1 - k]       = 1'b1;
                end
            end

            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    rem_reg[k] <= rem_next;
                    d_reg[k]   <= d_in;
                    q_reg[k]   <= q_next;
                end
            end
        end
    endgenerate

    assign quotient = q_reg[NS-1];

endmodule
`default_nettype wire

[rtl/core/aces_tm_lane.sv]
// One channel lane: rational fit numerator/denominator, then the divider.
// Depends on aces_tm_pkg and aces_tm_div.
`default_nettype none
module aces_tm_lane (
    input  wire logic                                   aclk,
    input  wire logic [aces_tm_pkg::LANE_STAGES-1:0]    en,
    input  wire logic [aces_tm_pkg::V_W-1:0]            v,
    output logic      [aces_tm_pkg::F_W-1:0]            f
);
    localparam int NW = aces_tm_pkg::NUM_W;
    localparam int DW = aces_tm_pkg::DIVD_W;
    localparam int FS = aces_tm_pkg::FIT_STAGES;

    localparam logic [57:0] FIT_A_EXT = 58'(aces_tm_pkg::FIT_A);

    // stage 1: squares and linear terms
    logic [61:0] vv_reg;
    logic [41:0] av_reg;
    logic [45:0] dv_reg;
    logic [57:0] av_full;
    logic [61:0] dv_full;

    // stage 2: c*v^2 split in two partial products
    logic [61:0]   hi_reg;
    logic [31:0]   lo_reg;
    logic [NW-1:0] npos_reg;
    logic [45:0]   dv2_reg;
    logic [63:0]   lo_full;

    // stage 3: numerator and denominator
    logic [NW-1:0] den_reg;
    logic [NW-1:0] num_reg;
    logic          pos_reg;

    // stage 4: range reduction
    logic [NW-1:0] divn_reg;
    logic [DW-1:0] divd_reg;
    logic [DW-1:0] nsh;
    logic [DW-1:0] dsh;

    assign av_full = 58'(FIT_A_EXT) * 58'(v);
    assign dv_full = 62'(aces_tm_pkg::FIT_D) * 62'(v);
    assign lo_full = 64'(vv_reg[31:0]) * 64'(aces_tm_pkg::FIT_C);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            vv_reg <= 62'(v) * 62'(v);
            av_reg <= av_full[57:16];
            dv_reg <= dv_full[61:16];
        end
        if (en[1]) begin
            hi_reg   <= 62'(vv_reg[61:32]) * 62'(aces_tm_pkg::FIT_C);
            lo_reg   <= lo_full[63:32];
            npos_reg <= NW'(vv_reg) + NW'(av_reg);
            dv2_reg  <= dv_reg;
        end
        if (en[2]) begin
            den_reg <= NW'(hi_reg) + NW'(lo_reg) + NW'(dv2_reg) + NW'(aces_tm_pkg::FIT_E);
            num_reg <= npos_reg - NW'(aces_tm_pkg::FIT_B);
            pos_reg <= npos_reg > NW'(aces_tm_pkg::FIT_B);
        end
        if (en[3]) begin
            divn_reg <= pos_reg ? {nsh, 16'd0} : '0;
            divd_reg <= dsh;
        end
    end

    // drop 16 bits from both terms once the denominator reaches 2^46
    always_comb begin
        if (den_reg[NW-1:46] != '0) begin
            nsh = num_reg[NW-1:16];
            dsh = den_reg[NW-1:16];
        end else begin
            nsh = num_reg[DW-1:0];
            dsh = den_reg[DW-1:0];
        end
    end

    aces_tm_div u_div (
        .aclk     (aclk),
        .en       (en[aces_tm_pkg::LANE_STAGES-1:FS]),
        .dividend (divn_reg),
        .divisor  (divd_reg),
        .quotient (f)
    );

endmodule
`default_nettype wire

[rtl/core/aces_tm_merge.sv]
// Output matrix across the three lanes, clamp to [0,1], output register.
// Depends on aces_tm_pkg.
`default_nettype none
module aces_tm_merge (
    input  wire logic                                                   aclk,
    input  wire logic [aces_tm_pkg::MERGE_STAGES-1:0]                   en,
    input  wire logic [aces_tm_pkg::N_CH-1:0][aces_tm_pkg::F_W-1:0]     f,
    output logic      [aces_tm_pkg::N_CH-1:0][aces_tm_pkg::OUT_W-1:0]   out
);
    localparam int NC = aces_tm_pkg::N_CH;
    localparam int PW = aces_tm_pkg::OPROD_W;
    localparam int SW = aces_tm_pkg::OSUM_W;
    localparam int OW = aces_tm_pkg::OUT_W;

    logic signed [PW-1:0] prod_reg [NC][NC];
    logic [NC-1:0][OW-1:0] out_reg;
    logic [NC-1:0][OW-1:0] out_next;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NC; i++) begin
            for (int j = 0; j < NC; j++) begin
                if (en[0]) begin
                    prod_reg[i][j] <= PW'($signed({1'b0, f[i]}) * aces_tm_pkg::OUT_MAT[i][j]);
                end
            end
        end
        if (en[1]) begin
            out_reg <= out_next;
        end
    end

    always_comb begin
        logic signed [SW-1:0] t;
        logic [SW-1:0]        rr;
        for (int j = 0; j < NC; j++) begin
            t = SW'(prod_reg[0][j]) + SW'(prod_reg[1][j]) + SW'(prod_reg[2][j]);
            rr = $unsigned(t) + SW'(32768);
            if (t <= 0) begin
                out_next[j] = '0;
            end else if (rr[SW-1:16] > (SW-16)'(aces_tm_pkg::OUT_MAX)) begin
                out_next[j] = aces_tm_pkg::OUT_MAX;
            end else begin
                out_next[j] = rr[OW+15:16];
            end
        end
    end

    assign out = out_reg;

endmodule
`default_nettype wire

[rtl/core/aces_filmic_tonemap.sv]
// ACES fitted filmic tonemapper, top level.
// Depends on aces_tm_pkg, aces_tm_lane, aces_tm_div and aces_tm_merge.
//
// Usage:
//   Input channel  s_tvalid/s_tready/s_tdata carries one linear HDR pixel
//   per transaction (red, green, blue, unsigned Q8.16). Output channel
//   m_tvalid/m_tready/m_tdata carries the tonemapped pixel (unsigned Q0.16
//   per channel, saturated to [0,1]).
//   The exposure multiplier (Q8.16) is written through cfg_wr_en /
//   cfg_wr_data; write it only while no pixel is in flight.
// Throughput and depth:
//   One pixel per clock while the receiver keeps m_tready high. The path
//   from input transaction to m_tvalid has 3 front stages (exposure,
//   input matrix), 4 fit stages and a 17-stage divider in each of three
//   channel lanes, and 2 merge stages (output matrix, clamp). The divider,
//   one quotient bit per stage, sets the depth.
// Reset:
//   aresetn (synchronous, active low) empties the pipeline, holds s_tready
//   low and loads the exposure multiplier with 1.0.
// Stall:
//   When the receiver holds m_tready low, the output register holds and
//   stages behind it keep advancing into empty slots; input is refused
//   only when every stage is full (and while reset is held).
`default_nettype none
module aces_filmic_tonemap (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [23:0] cfg_wr_data,   // exposure_scale
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,       // [23:0] in_red, [47:24] in_green, [71:48] in_blue
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata        // [15:0] out_red, [31:16] out_green, [47:32] out_blue
);
    localparam int NC  = aces_tm_pkg::N_CH;
    localparam int NS  = aces_tm_pkg::PIPE_STAGES;
    localparam int FS  = aces_tm_pkg::FRONT_STAGES;
    localparam int LS  = aces_tm_pkg::LANE_STAGES;
    localparam int PXW = aces_tm_pkg::PIX_W;
    localparam int PEW = aces_tm_pkg::PEXP_W;
    localparam int XW  = aces_tm_pkg::X_W;
    localparam int MPW = aces_tm_pkg::MPROD_W;
    localparam int VW  = aces_tm_pkg::V_W;

    logic [aces_tm_pkg::EXP_W-1:0] exposure_reg;

    // per-stage occupancy and advance enables
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] en;

    // front stages
    logic [PEW-1:0] pexp_reg [NC];
    logic [MPW-1:0] mprod_reg [NC][NC];
    logic [NC-1:0][VW-1:0] v_reg;
    logic [XW-1:0]  x [NC];
    logic [NC-1:0][VW-1:0] v_next;

    logic [NC-1:0][aces_tm_pkg::F_W-1:0]   f;
    logic [NC-1:0][aces_tm_pkg::OUT_W-1:0] out;

    // A stage advances when it is empty or the one after it advances.
    assign en[NS-1] = !vld_reg[NS-1] || m_tready;
    assign vld_next[0] = en[0] ? s_tvalid : vld_reg[0];

    genvar k;
    generate
        for (k = 0; k < NS - 1; k++) begin : g_en
            assign en[k] = !vld_reg[k] || en[k+1];
        end
        for (k = 1; k < NS; k++) begin : g_vld
            assign vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            exposure_reg <= aces_tm_pkg::EXPOSURE_RESET;
        end else begin
            vld_reg <= vld_next;
            if (cfg_wr_en) begin
                exposure_reg <= cfg_wr_data;
            end
        end
    end

    // Exposure, input matrix, round and saturate to Q15.16.
    always_comb begin
        logic [PEW:0]   xr;
        logic [MPW+2:0] sr;
        for (int i = 0; i < NC; i++) begin
            xr   = (PEW+1)'(pexp_reg[i]) + (PEW+1)'(32768);
            x[i] = xr[XW+15:16];
        end
        for (int j = 0; j < NC; j++) begin
            sr = (MPW+3)'(mprod_reg[0][j]) + (MPW+3)'(mprod_reg[1][j])
               + (MPW+3)'(mprod_reg[2][j]) + (MPW+3)'(32768);
            if (sr[MPW+2:16] > (MPW-13)'(aces_tm_pkg::V_SAT)) begin
                v_next[j] = aces_tm_pkg::V_SAT;
            end else begin
                v_next[j] = sr[VW+15:16];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NC; i++) begin
            if (en[0]) begin
                pexp_reg[i] <= PEW'(s_tdata[i*PXW +: PXW]) * PEW'(exposure_reg);
            end
            for (int j = 0; j < NC; j++) begin
                if (en[1]) begin
                    mprod_reg[i][j] <= MPW'(x[i]) * MPW'(aces_tm_pkg::IN_MAT[i][j]);
                end
            end
        end
        if (en[2]) begin
            v_reg <= v_next;
        end
    end

    generate
        for (k = 0; k < NC; k++) begin : g_lane
            aces_tm_lane u_lane (
                .aclk (aclk),
                .en   (en[FS+LS-1:FS]),
                .v    (v_reg[k]),
                .f    (f[k])
            );
        end
    endgenerate

    aces_tm_merge u_merge (
        .aclk (aclk),
        .en   (en[NS-1:FS+LS]),
        .f    (f),
        .out  (out)
    );

    // refuse transactions while reset is held
    assign s_tready = en[0] && aresetn;
    assign m_tvalid = vld_reg[NS-1];
    assign m_tdata  = out;

endmodule
`default_nettype wire
